[rtl/siti_pkg.sv]
// shared types and constants for the signed integer to decimal ascii unit
package siti_pkg;

  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 6;
  localparam int NUM_DIGITS = 19;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int STEP_W     = $clog2(VALUE_W);
  localparam int REMAIN_W   = $clog2(NUM_DIGITS);

  localparam logic [STEP_W-1:0]   STEP_LAST  = STEP_W'(VALUE_W - 1);
  localparam logic [REMAIN_W-1:0] REMAIN_TOP = REMAIN_W'(NUM_DIGITS - 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [3:0] DIGIT_ADJ     = 4'd3;

  typedef struct packed {
    logic               negative;
    logic [VALUE_W-1:0] magnitude;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } back_state_t;

endpackage

[rtl/siti_front.sv]
// front stage: accepts an integer, splits it into sign and unsigned magnitude
module siti_front import siti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [VALUE_W-1:0] value,
  output logic               full,
  output logic               q_push,
  output item_t              q_item,
  input  logic               q_full
);

  logic               held;
  item_t              item;
  logic               accept;
  logic [VALUE_W-1:0] raw;

  assign raw    = value;
  assign full   = held && q_full;
  assign accept = push && !full;
  assign q_push = held;
  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (!q_full) begin
      held <= 1'b0;
    end
  end

  // magnitude taken as unsigned, so the most negative value stays exact
  always_ff @(posedge clk) begin
    if (accept) begin
      item.negative  <= raw[VALUE_W-1];
      item.magnitude <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
    end
  end

endmodule

[rtl/siti_queue.sv]
// short queue of classified items between front and back
module siti_queue import siti_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item_in,
  output logic  full,
  input  logic  pop,
  output item_t item_out,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

[rtl/siti_back.sv]
// back stage: serial binary to bcd conversion and character emission
module siti_back import siti_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [CHAR_W-1:0] character,
  output logic              last_char
);

  back_state_t         state;
  back_state_t         state_next;
  logic [BCD_W-1:0]    bcd;
  logic [VALUE_W-1:0]  bin;
  logic [STEP_W-1:0]   step;
  logic [REMAIN_W-1:0] remain;
  logic                negative;
  logic [3:0]          top;
  logic                take;
  logic [BCD_W-1:0]    bcd_adj;

  assign top  = bcd[BCD_W-1 -: 4];
  assign take = pop && !empty;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= DIGIT_ADJ_MIN) ?
                          bcd[4*d +: 4] + DIGIT_ADJ : bcd[4*d +: 4];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (!q_empty) state_next = ST_CONV;
      ST_CONV:  if (step == STEP_LAST) state_next = ST_SKIP;
      ST_SKIP: begin
        if (top != 4'd0 || remain == '0) begin
          state_next = negative ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN:  if (take) state_next = ST_DIGIT;
      ST_DIGIT: if (take && remain == '0) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == ST_IDLE) && !q_empty;
    empty     = !((state == ST_SIGN) || (state == ST_DIGIT));
    character = (state == ST_SIGN) ? ASCII_MINUS : ASCII_ZERO + {2'b00, top};
    last_char = (state == ST_DIGIT) && (remain == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          bin      <= q_item.magnitude;
          negative <= q_item.negative;
          bcd      <= '0;
          step     <= '0;
          remain   <= REMAIN_TOP;
        end
      end
      ST_CONV: begin
        {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
        step       <= step + 1'b1;
      end
      ST_SKIP: begin
        if (top == 4'd0 && remain != '0) begin
          bcd    <= {bcd[BCD_W-5:0], 4'd0};
          remain <= remain - 1'b1;
        end
      end
      ST_DIGIT: begin
        if (take && remain != '0) begin
          bcd    <= {bcd[BCD_W-5:0], 4'd0};
          remain <= remain - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (character == ASCII_MINUS ||
                (character >= ASCII_ZERO && character <= ASCII_NINE)))
    else $error("character out of range");

  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    (take && !last_char) |=> !empty)
    else $error("gap inside a number's text");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && state == ST_SIGN) |-> !last_char)
    else $error("minus sign flagged as last");

endmodule

[rtl/signed_int_to_decimal_ascii_unit.sv]
// top level of the signed integer to decimal ascii unit
// Converts one signed 64-bit integer per item into its decimal text, one ASCII
// character per result, most significant first, with a leading minus sign for
// negative values; zero gives a single '0' and the final character of each
// number carries last_char. The most negative value is written in full (20
// characters). A front stage takes the item and forms sign and unsigned
// magnitude, a short queue of QUEUE_DEPTH items holds them, and a back stage
// converts by bit-serial shift-and-add-three (one bit per cycle) and then
// emits: for each number it loads the item, converts all 64 magnitude bits,
// skips leading zeros, then sends the minus sign when negative and the
// digits. Input items keep flowing into the queue while the back stage
// works, so push sees full only when the queue and the front register are
// both occupied. No state is kept between numbers.
module signed_int_to_decimal_ascii_unit import siti_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  // input side
  input  logic               push,
  input  logic [VALUE_W-1:0] value,
  output logic               full,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic [CHAR_W-1:0]  character,
  output logic               last_char
);

  // front to queue
  logic  f_push;
  item_t f_item;
  logic  f_full;
  // queue to back
  item_t b_item;
  logic  b_empty;
  logic  b_pop;

  // sign split and magnitude register
  siti_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .value  (value),
    .full   (full),
    .q_push (f_push),
    .q_item (f_item),
    .q_full (f_full)
  );

  // decouples the input side from the long conversion
  siti_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .item_in  (f_item),
    .full     (f_full),
    .pop      (b_pop),
    .item_out (b_item),
    .empty    (b_empty)
  );

  // bcd conversion, leading zero skip, character output
  siti_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (b_empty),
    .q_item    (b_item),
    .q_pop     (b_pop),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .last_char (last_char)
  );

endmodule

[test/siti_text_checker.sv]
`timescale 1ns / 100ps
// checker that predicts the decimal text of each number and compares it with the result channel
module siti_text_checker import siti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [VALUE_W-1:0] value,
  input  logic               empty,
  input  logic               pop,
  input  logic [CHAR_W-1:0]  character,
  input  logic               last_char,
  output int                 fail_count,
  output int                 chars_pending,
  output int                 chars_checked
);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  text_char_t expected_text [$];
  int         fails   = 0;
  int         checked = 0;

  // appends the characters one number should produce
  task automatic spell_value(input logic [VALUE_W-1:0] v);
    logic [CHAR_W-1:0]  digits_rev [20];
    logic [VALUE_W-1:0] mag;
    text_char_t         c;
    int                 ndig;
    mag  = v[VALUE_W-1] ? (~v + 1'b1) : v;
    ndig = 0;
    do begin
      digits_rev[ndig] = ASCII_ZERO + CHAR_W'(mag % 10);
      mag              = mag / 10;
      ndig++;
    end while (mag != 0);
    if (v[VALUE_W-1]) begin
      c.code = ASCII_MINUS;
      c.last = 1'b0;
      expected_text.insert(expected_text.size(), c);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      c.code = digits_rev[i];
      c.last = (i == 0);
      expected_text.insert(expected_text.size(), c);
    end
  endtask

  always @(posedge clk) begin : watch_channels
    text_char_t want;
    if (!rst) begin
      if (push && !full) begin
        spell_value(value);
      end
      if (pop && !empty) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character %0d last %0b, nothing expected",
                   $time, character, last_char);
          fails++;
        end else begin
          want = expected_text.pop_front();
          checked++;
          if (character !== want.code) begin
            $display("%0t: character expected %0d, got %0d", $time, want.code, character);
            fails++;
          end
          if (last_char !== want.last) begin
            $display("%0t: last_char expected %0b, got %0b", $time, want.last, last_char);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    chars_pending <= expected_text.size();
    chars_checked <= checked;
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// testbench top for the signed integer to decimal ascii unit: stimulus, idling and verdict
module tb_top;
  import siti_pkg::*;

  // no item moving for this many cycles means the block has hung; the limit lies
  // well beyond one number's time in the back stage and the longest sender gap
  localparam int WATCHDOG_LIMIT = 3000;
  // quiet cycles after the last character, well beyond one conversion
  localparam int DRAIN_CYCLES   = 200;
  localparam int DIRECTED_ITEMS = 22;
  localparam int RANDOM_ITEMS   = 440;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               push  = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               pop   = 1'b0;
  logic               full;
  logic               empty;
  logic [CHAR_W-1:0]  character;
  logic               last_char;

  int fail_count;
  int chars_pending;
  int chars_checked;

  // sender bookkeeping
  int burst_left     = 0;
  int numbers_sent   = 0;
  int negatives_sent = 0;
  int directed_sent  = 0;

  // receiver pattern state
  int pop_mode      = 0;
  int pop_mode_left = 0;
  int pop_stall     = 0;

  int idle_cycles = 0;

  signed_int_to_decimal_ascii_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .value     (value),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .last_char (last_char)
  );

  siti_text_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .value         (value),
    .empty         (empty),
    .pop           (pop),
    .character     (character),
    .last_char     (last_char),
    .fail_count    (fail_count),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // 10 to the power n, n up to 18
  function automatic logic [VALUE_W-1:0] ten_power(input int n);
    logic [VALUE_W-1:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  // directed numbers: zero, single digits, digit-count boundaries, both
  // extremes (the most negative value gives the full 20 characters) and
  // alternating bit patterns
  function automatic logic [VALUE_W-1:0] directed_value(input int idx);
    case (idx)
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return -64'sd1;
      3:       return 64'd9;
      4:       return -64'sd9;
      5:       return 64'd10;
      6:       return -64'sd10;
      7:       return 64'd99;
      8:       return 64'd100;
      9:       return 64'd12345;
      10:      return -64'sd12345;
      11:      return 64'h7FFF_FFFF_FFFF_FFFF;
      12:      return 64'h8000_0000_0000_0000;
      13:      return 64'h8000_0000_0000_0001;
      14:      return 64'sd999999999999999999;
      15:      return -64'sd999999999999999999;
      16:      return 64'sd1000000000000000000;
      17:      return -64'sd1000000000000000000;
      18:      return 64'h5555_5555_5555_5555;
      19:      return 64'hAAAA_AAAA_AAAA_AAAA;
      20:      return 64'd4294967295;
      default: return -64'sd4294967296;
    endcase
  endfunction

  // random numbers spread over digit counts, raw bit patterns, powers of ten,
  // small values and the neighborhood of both extremes
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] span;
    logic [VALUE_W-1:0] mag;
    int                 digits;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // uniform digit count, then a magnitude with exactly that many digits
        digits = $urandom_range(1, 19);
        lo     = ten_power(digits - 1);
        span   = (digits == 19) ? (64'h7FFF_FFFF_FFFF_FFFF - lo + 1) : (ten_power(digits) - lo);
        mag    = lo + raw % span;
        return $urandom_range(0, 1) ? -mag : mag;
      end
      4, 5:
        return raw;
      6: begin
        // one below, at, or one above a power of ten
        mag = ten_power($urandom_range(0, 18)) + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? -mag : mag;
      end
      7:
        return VALUE_W'($urandom_range(0, 40)) - 64'd20;
      8:
        return raw[0] ? 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 9)
                      : 64'h8000_0000_0000_0000 + $urandom_range(0, 9);
      default: begin
        mag = raw >> $urandom_range(0, 63);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  // offers one number and holds it until the block takes it; between bursts
  // the sender goes quiet for a short or a long gap
  task automatic send_value(input logic [VALUE_W-1:0] v);
    push  <= 1'b1;
    value <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    numbers_sent++;
    if (v[VALUE_W-1]) negatives_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      // long gaps let the back stage run dry mid conversion
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(40, 160)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long stretch with push held high
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(30, 60);
      else burst_left = $urandom_range(0, 12);
    end
  endtask

  // receiver: a run of cycles in one mode, then another mode
  // modes: always ready, mostly ready, mostly stalled, ready with stall bursts
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_mode_left == 0) begin
        pop_mode      = $urandom_range(0, 3);
        pop_mode_left = $urandom_range(30, 400);
        pop_stall     = 0;
      end
      pop_mode_left--;
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: begin
          if (pop_stall > 0) begin
            pop_stall--;
            pop <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            pop_stall = $urandom_range(1, 10);
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
          end
        end
      endcase
    end
  end

  // watchdog: ends the run if no item moves on either side for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no item moved for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = $urandom_range(0, 8);

    // directed part first
    for (int i = 0; i < DIRECTED_ITEMS; i++) send_value(directed_value(i));
    directed_sent = numbers_sent;

    // random part
    repeat (RANDOM_ITEMS) send_value(random_value());
    push <= 1'b0;

    // let the checker's count take in the last number, then drain
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d numbers (%0d directed, %0d negative)",
             numbers_sent, directed_sent, negatives_sent);
    $display("%0d characters compared, %0d failures", chars_checked, fail_count);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[signed_int_to_decimal_ascii_unit.f]
rtl/siti_pkg.sv
rtl/siti_front.sv
rtl/siti_queue.sv
rtl/siti_back.sv
rtl/signed_int_to_decimal_ascii_unit.sv
test/siti_text_checker.sv
test/tb_top.sv
